// ----- rtl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants and types for the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

  // slots in the table memory
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // field widths
  localparam int MODE_W = 2;
  localparam int KEY_W  = 64;
  localparam int OFF_W  = 64;
  localparam int CAP_W  = 11;

  // slot position width: positions stay below min(TABLE_DEPTH, 2^CAP_W)
  localparam int POS_W = (ADDR_W < CAP_W) ? ADDR_W : CAP_W;
  localparam int CMP_W = CAP_W + 1;

  // modulo unit: dividend bits consumed per cycle
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = KEY_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK
  } state_t;

endpackage

// ----- rtl/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open-addressing hash table with linear probing, 64-bit key hash and offset
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on hit, found_offset and status for exactly one cycle with done high,
// and must be captured then, since the receiver cannot stall the block. A
// lookup or insert first reduces key_hash modulo the slots in use with a
// shared compare-subtract unit that takes 4 bits a cycle, then probes the
// table one slot at a time, each probe a ST_READ and a ST_CHECK state, through
// the registered read port of the slot memory. A key hash of zero, mode 3, and
// an insert or lookup with capacity zero answer in the cycle after they are
// taken. A clear sweeps all 1024 slots one per cycle and then answers. After
// reset the same clearing pass runs with busy high and no result. Capacity is
// written through cfg_we/cfg_wdata at any time (values above the table depth
// act as the depth) but should only change while the block is idle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [lpht_pkg::CAP_W-1:0]  cfg_wdata,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  logic [lpht_pkg::MODE_W-1:0] mode,
  input  logic [lpht_pkg::KEY_W-1:0]  key_hash,
  input  logic [lpht_pkg::OFF_W-1:0]  value_offset,
  // result side
  output logic                        done,
  output logic                        hit,
  output logic [lpht_pkg::OFF_W-1:0]  found_offset,
  output logic                        status
);

  import lpht_pkg::*;

  // slot memories
  logic [KEY_W-1:0] hash_mem [TABLE_DEPTH];
  logic [OFF_W-1:0] off_mem  [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_hash;
  logic [OFF_W-1:0] rd_off;

  // configuration register
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] n_eff;

  // control state
  state_t              state, state_next;
  logic                done_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic                clr_reply, clr_reply_next;

  // transaction payload
  mode_t               mode_r, mode_next;
  logic [KEY_W-1:0]    key_r, key_next;
  logic [OFF_W-1:0]    val_r, val_next;
  logic [CAP_W-1:0]    n_r, n_next;
  logic [KEY_W-1:0]    div_sh, div_sh_next;
  logic [POS_W-1:0]    rem, rem_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [CAP_W-1:0]    probes, probes_next;
  logic                hit_next, status_next;
  logic [OFF_W-1:0]    found_offset_next;

  // memory write port
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [KEY_W-1:0]    wr_hash;
  logic                off_we;

  // shared modulo unit output
  logic [POS_W-1:0]    div_rem;

  // probe helpers
  logic [CAP_W-1:0]    probes_inc;
  logic [CAP_W:0]      pos_inc;
  logic [POS_W-1:0]    pos_wrap;

  assign busy = (state != ST_IDLE);

  // slots in use, clamped to the table depth
  always_comb begin
    if (int'(capacity) > TABLE_DEPTH) begin
      n_eff = CAP_W'(TABLE_DEPTH);
    end else begin
      n_eff = capacity;
    end
  end

  // restoring modulo unit, DIV_STEPS dividend bits per cycle
  always_comb begin
    logic [CMP_W-1:0] acc;
    logic [POS_W-1:0] r;
    r = rem;
    for (int i = 0; i < DIV_STEPS; i++) begin
      acc = CMP_W'({r, div_sh[KEY_W-1-i]});
      if (acc >= CMP_W'(n_r)) begin
        acc = acc - CMP_W'(n_r);
      end
      r = acc[POS_W-1:0];
    end
    div_rem = r;
  end

  // next probe position with wrap at the slots in use
  assign probes_inc = probes + CAP_W'(1);
  assign pos_inc    = (CAP_W + 1)'(pos) + (CAP_W + 1)'(1);
  assign pos_wrap   = (pos_inc == (CAP_W + 1)'(n_r)) ? '0 : pos_inc[POS_W-1:0];

  // sequencer
  always_comb begin
    state_next        = state;
    done_next         = 1'b0;
    clr_addr_next     = clr_addr;
    clr_reply_next    = clr_reply;
    mode_next         = mode_r;
    key_next          = key_r;
    val_next          = val_r;
    n_next            = n_r;
    div_sh_next       = div_sh;
    rem_next          = rem;
    div_cnt_next      = div_cnt;
    pos_next          = pos;
    probes_next       = probes;
    hit_next          = hit;
    found_offset_next = found_offset;
    status_next       = status;
    wr_en             = 1'b0;
    wr_addr           = ADDR_W'(pos);
    wr_hash           = '0;
    off_we            = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        // sweep one slot per cycle back to empty
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next     = ST_IDLE;
          clr_addr_next  = '0;
          clr_reply_next = 1'b0;
          if (clr_reply) begin
            done_next         = 1'b1;
            hit_next          = 1'b0;
            found_offset_next = '0;
            status_next       = 1'b0;
          end
        end
      end

      ST_IDLE: begin
        if (start) begin
          mode_next         = mode_t'(mode);
          key_next          = key_hash;
          val_next          = value_offset;
          n_next            = n_eff;
          div_sh_next       = key_hash;
          rem_next          = '0;
          div_cnt_next      = '0;
          probes_next       = '0;
          hit_next          = 1'b0;
          found_offset_next = '0;
          status_next       = 1'b0;
          unique case (mode_t'(mode))
            MODE_LOOKUP: begin
              if (n_eff == '0 || key_hash == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = ST_DIV;
              end
            end
            MODE_INSERT: begin
              priority if (key_hash == '0) begin
                done_next = 1'b1;
              end else if (n_eff == '0) begin
                done_next   = 1'b1;
                status_next = 1'b1;
              end else begin
                state_next = ST_DIV;
              end
            end
            MODE_CLEAR: begin
              state_next     = ST_CLEAR;
              clr_addr_next  = '0;
              clr_reply_next = 1'b1;
            end
            MODE_NOP: begin
              done_next = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_DIV: begin
        rem_next     = div_rem;
        div_sh_next  = div_sh << DIV_STEPS;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
          pos_next   = div_rem;
          state_next = ST_READ;
        end
      end

      ST_READ: begin
        // slot data registers at the end of this cycle
        state_next = ST_CHECK;
      end

      ST_CHECK: begin
        priority if (rd_hash == '0) begin
          // empty slot ends the probe run
          if (mode_r == MODE_INSERT) begin
            wr_en   = 1'b1;
            wr_hash = key_r;
            off_we  = 1'b1;
          end
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (mode_r == MODE_LOOKUP && rd_hash == key_r) begin
          done_next         = 1'b1;
          hit_next          = 1'b1;
          found_offset_next = rd_off;
          state_next        = ST_IDLE;
        end else if (probes_inc == n_r) begin
          // every slot in use probed
          done_next   = 1'b1;
          status_next = (mode_r == MODE_INSERT);
          state_next  = ST_IDLE;
        end else begin
          pos_next    = pos_wrap;
          probes_next = probes_inc;
          state_next  = ST_READ;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      done      <= 1'b0;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      capacity  <= CAP_RESET;
    end else begin
      state     <= state_next;
      done      <= done_next;
      clr_addr  <= clr_addr_next;
      clr_reply <= clr_reply_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_next;
    key_r        <= key_next;
    val_r        <= val_next;
    n_r          <= n_next;
    div_sh       <= div_sh_next;
    rem          <= rem_next;
    div_cnt      <= div_cnt_next;
    pos          <= pos_next;
    probes       <= probes_next;
    hit          <= hit_next;
    found_offset <= found_offset_next;
    status       <= status_next;
  end

  // slot hash memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hash_mem[wr_addr] <= wr_hash;
    end
    rd_hash <= hash_mem[ADDR_W'(pos)];
  end

  // slot offset memory, only read where a hash was written with it
  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[ADDR_W'(pos)] <= val_r;
    end
    rd_off <= off_mem[ADDR_W'(pos)];
  end

endmodule
